FILE: src/nlt_pkg.sv
`default_nettype none
package nlt_pkg;

	localparam int MAX_DEGREE_DEF = 7;
	localparam int FLD_W = 3;
	localparam int ANGLE_W = 31;
	localparam int ENT_W = 32;
	localparam int TRIG_W = 34;
	localparam int COEF_W = 34;
	localparam int Z_W = 36;
	localparam int R_W = 36;
	localparam int ACC_W = 40;
	localparam int PROD_W = 66;
	localparam int FRAC_SH = 30;
	localparam int OUT_SH = 4;
	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W = 5;
	localparam int TAB_NW = 3;
	localparam int TAB_IW = 2 * TAB_NW;
	localparam int TAB_N = 1 << TAB_NW;
	localparam int PC_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic signed [TRIG_W-1:0] GAIN_INV = TRIG_W'(652032874);
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(64'd1686629713);
	localparam logic signed [Z_W-1:0] PI_Q30 = Z_W'(64'd3373259426);
	localparam logic signed [ENT_W-1:0] ONE_Q24 = ENT_W'(1 << 24);
	localparam logic signed [ACC_W-1:0] LIM31 = ACC_W'(64'd2147483647);

	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEGREE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ORDER = CFG_IDX_W'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_INIT,
		ST_LD0,
		ST_LD1,
		ST_LD2,
		ST_MUL,
		ST_WB,
		ST_EM_RD,
		ST_EM_LD,
		ST_EM_OUT
	} state_t;

	typedef enum logic [2:0] {X_P1, X_D1, X_P2, X_D2, X_ACC, X_TMP} xsel_t;
	typedef enum logic [1:0] {K_C, K_S, K_COEF} ksel_t;
	typedef enum logic [2:0] {CF_DG, CF_E, CF_A, CF_B, CF_CC} cf_t;
	typedef enum logic [2:0] {DST_TMP, DST_LD, DST_ADD, DST_SUB, DST_WR_P, DST_WR_D} dst_t;
	typedef enum logic [1:0] {MO_DIAG, MO_SUB, MO_COL} mo_t;

	typedef struct packed {
		xsel_t xs;
		ksel_t ks;
		cf_t   cf;
		dst_t  dst;
		mo_t   mo;
		logic  last;
	} uop_t;

	typedef logic [TAB_N*TAB_N-1:0][COEF_W-1:0] coef_tab_t;

	function automatic uop_t mk(input xsel_t xs, input ksel_t ks, input cf_t cf,
			input dst_t dst, input mo_t mo, input logic last);
		uop_t u;
		u.xs = xs;
		u.ks = ks;
		u.cf = cf;
		u.dst = dst;
		u.mo = mo;
		u.last = last;
		return u;
	endfunction

	// diagonal job: pair (n,n) and (n,n-1); column job: entry (n,m)
	function automatic uop_t uop_rom(input logic col, input logic [PC_W-1:0] pc);
		uop_t u;
		u = mk(X_ACC, K_COEF, CF_A, DST_TMP, MO_COL, 1'b1);
		unique case ({col, pc})
			5'h00: u = mk(X_P1, K_C, CF_DG, DST_TMP, MO_DIAG, 1'b0);
			5'h01: u = mk(X_TMP, K_COEF, CF_DG, DST_WR_P, MO_DIAG, 1'b0);
			5'h02: u = mk(X_D1, K_C, CF_DG, DST_LD, MO_DIAG, 1'b0);
			5'h03: u = mk(X_P1, K_S, CF_DG, DST_SUB, MO_DIAG, 1'b0);
			5'h04: u = mk(X_ACC, K_COEF, CF_DG, DST_WR_D, MO_DIAG, 1'b0);
			5'h05: u = mk(X_P1, K_S, CF_E, DST_TMP, MO_SUB, 1'b0);
			5'h06: u = mk(X_TMP, K_COEF, CF_E, DST_WR_P, MO_SUB, 1'b0);
			5'h07: u = mk(X_P1, K_C, CF_E, DST_LD, MO_SUB, 1'b0);
			5'h08: u = mk(X_D1, K_S, CF_E, DST_ADD, MO_SUB, 1'b0);
			5'h09: u = mk(X_ACC, K_COEF, CF_E, DST_WR_D, MO_SUB, 1'b1);
			5'h10: u = mk(X_P1, K_S, CF_B, DST_TMP, MO_COL, 1'b0);
			5'h11: u = mk(X_TMP, K_COEF, CF_B, DST_LD, MO_COL, 1'b0);
			5'h12: u = mk(X_P2, K_COEF, CF_CC, DST_SUB, MO_COL, 1'b0);
			5'h13: u = mk(X_ACC, K_COEF, CF_A, DST_WR_P, MO_COL, 1'b0);
			5'h14: u = mk(X_D1, K_S, CF_B, DST_TMP, MO_COL, 1'b0);
			5'h15: u = mk(X_TMP, K_COEF, CF_B, DST_LD, MO_COL, 1'b0);
			5'h16: u = mk(X_P1, K_C, CF_B, DST_TMP, MO_COL, 1'b0);
			5'h17: u = mk(X_TMP, K_COEF, CF_B, DST_ADD, MO_COL, 1'b0);
			5'h18: u = mk(X_D2, K_COEF, CF_CC, DST_SUB, MO_COL, 1'b0);
			5'h19: u = mk(X_ACC, K_COEF, CF_A, DST_WR_D, MO_COL, 1'b1);
			default: u = mk(X_ACC, K_COEF, CF_A, DST_TMP, MO_COL, 1'b1);
		endcase
		return u;
	endfunction

	function automatic logic [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
		logic [Z_W-1:0] a;
		unique case (i)
			5'd0:  a = Z_W'(843314856);
			5'd1:  a = Z_W'(497837829);
			5'd2:  a = Z_W'(263043836);
			5'd3:  a = Z_W'(133525158);
			5'd4:  a = Z_W'(67021686);
			5'd5:  a = Z_W'(33543515);
			5'd6:  a = Z_W'(16775850);
			5'd7:  a = Z_W'(8388437);
			5'd8:  a = Z_W'(4194282);
			5'd9:  a = Z_W'(2097149);
			5'd10: a = Z_W'(1048575);
			5'd11: a = Z_W'(524287);
			5'd12: a = Z_W'(262143);
			5'd13: a = Z_W'(131071);
			5'd14: a = Z_W'(65535);
			5'd15: a = Z_W'(32767);
			5'd16: a = Z_W'(16383);
			5'd17: a = Z_W'(8191);
			5'd18: a = Z_W'(4095);
			5'd19: a = Z_W'(2047);
			5'd20: a = Z_W'(1023);
			5'd21: a = Z_W'(511);
			5'd22: a = Z_W'(255);
			5'd23: a = Z_W'(127);
			5'd24: a = Z_W'(63);
			5'd25: a = Z_W'(31);
			5'd26: a = Z_W'(15);
			5'd27: a = Z_W'(7);
			5'd28: a = Z_W'(3);
			5'd29: a = Z_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic logic signed [ENT_W-1:0] sat31(input logic signed [ACC_W-1:0] v);
		logic signed [ENT_W-1:0] r;
		if (v > LIM31) begin
			r = LIM31[ENT_W-1:0];
		end else if (v < -LIM31) begin
			r = ENT_W'(-LIM31);
		end else begin
			r = v[ENT_W-1:0];
		end
		return r;
	endfunction

	// elaboration-time helpers for the coefficient tables
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] b;
		x = x_in;
		res = '0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [COEF_W-1:0] coef_q30(input logic [63:0] p, input logic [63:0] q);
		logic [63:0] u;
		logic [63:0] hi;
		logic [63:0] rem;
		logic [63:0] frac;
		u = p << 56;
		hi = '0;
		rem = '0;
		frac = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], u[i]};
			if (rem >= q) begin
				rem = rem - q;
				hi[i] = 1'b1;
			end
		end
		for (int i = 3; i >= 0; i--) begin
			rem = {rem[62:0], 1'b0};
			if (rem >= q) begin
				rem = rem - q;
				frac[i] = 1'b1;
			end
		end
		return COEF_W'(isqrt64((hi << 4) + frac));
	endfunction

	function automatic coef_tab_t build_tab(input cf_t kind);
		coef_tab_t tab;
		int p;
		int q;
		logic ok;
		for (int n = 0; n < TAB_N; n++) begin
			for (int m = 0; m < TAB_N; m++) begin
				p = 0;
				q = 1;
				ok = 1'b0;
				unique case (kind)
					CF_DG: begin
						ok = (n >= 1);
						p = (n == 1) ? 3 : 2 * n + 1;
						q = (n == 1) ? 1 : 2 * n;
					end
					CF_E: begin
						ok = (n >= 1);
						p = 2 * n + 1;
					end
					CF_B: begin
						ok = (n >= 2);
						p = 2 * n - 1;
					end
					CF_A: begin
						ok = (n >= m + 2);
						p = 2 * n + 1;
						q = ok ? (n - m) * (n + m) : 1;
					end
					CF_CC: begin
						ok = (n >= m + 2);
						p = ok ? (n + m - 1) * (n - m - 1) : 0;
						q = ok ? 2 * n - 3 : 1;
					end
					default: ok = 1'b0;
				endcase
				tab[n * TAB_N + m] = ok ? coef_q30(64'(p), 64'(q)) : '0;
			end
		end
		return tab;
	endfunction

endpackage
`default_nettype wire

FILE: src/nlt_cordic.sv
`default_nettype none
module nlt_cordic
	import nlt_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic signed [ANGLE_W-1:0] angle,
	output logic                           done,
	output logic signed [TRIG_W-1:0]       cos_val,
	output logic signed [TRIG_W-1:0]       sin_val
);

	logic                     busy_q;
	logic                     done_q;
	logic                     flip_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [TRIG_W-1:0] x_q;
	logic signed [TRIG_W-1:0] y_q;
	logic signed [Z_W-1:0]    z_q;

	logic signed [Z_W-1:0]    z_in;
	logic signed [Z_W-1:0]    z_red;
	logic                     flip_in;
	logic signed [TRIG_W-1:0] dx;
	logic signed [TRIG_W-1:0] dy;
	logic signed [Z_W-1:0]    at;

	// fold the angle into +-pi/2; sine and cosine flip sign
	always_comb begin
		z_in = Z_W'(angle) <<< 2;
		z_red = z_in;
		flip_in = 1'b0;
		priority if (z_in > HALF_PI_Q30) begin
			z_red = z_in - PI_Q30;
			flip_in = 1'b1;
		end else if (z_in < -HALF_PI_Q30) begin
			z_red = z_in + PI_Q30;
			flip_in = 1'b1;
		end else begin
			z_red = z_in;
		end
	end

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign at = $signed(atan_q30(step_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= GAIN_INV;
			y_q <= '0;
			z_q <= z_red;
			flip_q <= flip_in;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule
`default_nettype wire

FILE: src/normalized_legendre_table_core.sv
`default_nettype none
// Flow: CORDIC rotation, an init step, then J jobs on one shared multiplier
// (J = D + D*(D-1)/2 for D = MAX_DEGREE, 28 at the default).
// Emission: ST_EM_RD, ST_EM_LD, ST_EM_OUT per entry; ST_EM_OUT holds while stalled.
// A new angle is taken only in idle, once the previous table's last entry is accepted.
// Reset (arst_n low, asynchronous): idle, no beat pending, both limits set to 7.
// Table memories need no clearing; every entry used is written earlier for the same angle.
module normalized_legendre_table_core
	import nlt_pkg::*;
#(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [31:0]          s_axis_tdata,  // [30:0] angle
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [71:0]               m_axis_tdata,  // [2:0] degree, [5:3] order,
	                                                 // [37:6] value, [69:38] derivative
	output logic                      m_axis_tlast,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FLD_W-1:0]     cfg_data
);

	localparam int NW = $clog2(MAX_DEGREE + 1);
	localparam int AW = 2 * NW;
	localparam int DEPTH = 1 << AW;
	localparam logic [NW-1:0] MAXN = NW'(MAX_DEGREE);
	localparam logic [NW-1:0] LAST_M = NW'((MAX_DEGREE >= 2) ? MAX_DEGREE - 2 : 0);
	localparam logic [FLD_W-1:0] MAXN_F = FLD_W'(MAX_DEGREE);

	localparam coef_tab_t DG_TAB = build_tab(CF_DG);
	localparam coef_tab_t E_TAB = build_tab(CF_E);
	localparam coef_tab_t A_TAB = build_tab(CF_A);
	localparam coef_tab_t B_TAB = build_tab(CF_B);
	localparam coef_tab_t CC_TAB = build_tab(CF_CC);

	state_t state_q, state_d;

	logic [FLD_W-1:0] max_degree_q;
	logic [FLD_W-1:0] max_order_q;

	logic                     cord_start;
	logic                     cord_done;
	logic signed [TRIG_W-1:0] cos_w;
	logic signed [TRIG_W-1:0] sin_w;

	logic [NW-1:0]   jn_q;
	logic [NW-1:0]   jm_q;
	logic            jcol_q;
	logic [PC_W-1:0] pc_q;
	uop_t            uop;
	logic            jobs_done;

	logic signed [ENT_W-1:0] mem_p [DEPTH];
	logic signed [ENT_W-1:0] mem_d [DEPTH];
	logic signed [ENT_W-1:0] rd_p_q;
	logic signed [ENT_W-1:0] rd_d_q;
	logic [AW-1:0]           raddr;
	logic [AW-1:0]           waddr;
	logic                    we_p;
	logic                    we_d;
	logic signed [ENT_W-1:0] wdata_p;
	logic signed [ENT_W-1:0] wdata_d;

	logic signed [ENT_W-1:0]  p1_q, d1_q, p2_q, d2_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [R_W-1:0]    tmp_q;
	logic signed [PROD_W-1:0] prod_s1;

	logic signed [ACC_W-1:0]  xw;
	logic signed [ENT_W-1:0]  xs;
	logic signed [COEF_W-1:0] kv;
	logic [COEF_W-1:0]        coef;
	logic [TAB_IW-1:0]        cidx;
	logic signed [R_W-1:0]    r;
	logic signed [ACC_W-1:0]  r_ext;
	logic signed [ENT_W-1:0]  r_sat;
	logic [NW-1:0]            wm;

	logic [FLD_W-1:0]        en_q;
	logic [FLD_W-1:0]        em_q;
	logic [FLD_W-1:0]        nd;
	logic                    em_last;
	logic [FLD_W-1:0]        out_deg_q;
	logic [FLD_W-1:0]        out_ord_q;
	logic signed [ENT_W-1:0] out_val_q;
	logic signed [ENT_W-1:0] out_der_q;
	logic                    out_last_q;

	nlt_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cord_start),
		.angle   (s_axis_tdata[ANGLE_W-1:0]),
		.done    (cord_done),
		.cos_val (cos_w),
		.sin_val (sin_w)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_degree_q <= FLD_W'(7);
			max_order_q <= FLD_W'(7);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_DEGREE: max_degree_q <= cfg_data;
				REG_MAX_ORDER:  max_order_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign uop = uop_rom(jcol_q, pc_q);
	assign jobs_done = jcol_q ? (jn_q == MAXN && jm_q == LAST_M)
		: (jn_q == MAXN && MAX_DEGREE < 2);
	assign nd = (max_degree_q > MAXN_F) ? MAXN_F : max_degree_q;
	assign em_last = (en_q == nd) && (em_q == max_order_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_axis_tvalid) state_d = ST_CORDIC;
			ST_CORDIC: if (cord_done) state_d = ST_INIT;
			ST_INIT:   state_d = ST_LD0;
			ST_LD0:    state_d = ST_LD1;
			ST_LD1:    state_d = ST_LD2;
			ST_LD2:    state_d = ST_MUL;
			ST_MUL:    state_d = ST_WB;
			ST_WB: begin
				priority if (!uop.last) state_d = ST_MUL;
				else if (jobs_done) state_d = ST_EM_RD;
				else state_d = ST_LD0;
			end
			ST_EM_RD:  state_d = ST_EM_LD;
			ST_EM_LD:  state_d = ST_EM_OUT;
			ST_EM_OUT: begin
				if (m_axis_tready) state_d = out_last_q ? ST_IDLE : ST_EM_RD;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// datapath operand selection
	always_comb begin
		unique case (uop.xs)
			X_P1:    xw = ACC_W'(p1_q);
			X_D1:    xw = ACC_W'(d1_q);
			X_P2:    xw = ACC_W'(p2_q);
			X_D2:    xw = ACC_W'(d2_q);
			X_ACC:   xw = acc_q;
			X_TMP:   xw = ACC_W'(tmp_q);
			default: xw = acc_q;
		endcase
		xs = sat31(xw);
		cidx = {TAB_NW'(jn_q), TAB_NW'(jm_q)};
		unique case (uop.cf)
			CF_DG:   coef = DG_TAB[cidx];
			CF_E:    coef = E_TAB[cidx];
			CF_A:    coef = A_TAB[cidx];
			CF_B:    coef = B_TAB[cidx];
			CF_CC:   coef = CC_TAB[cidx];
			default: coef = '0;
		endcase
		unique case (uop.ks)
			K_C:     kv = cos_w;
			K_S:     kv = sin_w;
			K_COEF:  kv = $signed(coef);
			default: kv = '0;
		endcase
		r = prod_s1[PROD_W-1:FRAC_SH];
		r_ext = ACC_W'(r);
		r_sat = sat31(r_ext);
		unique case (uop.mo)
			MO_DIAG: wm = jn_q;
			MO_SUB:  wm = jn_q - NW'(1);
			MO_COL:  wm = jm_q;
			default: wm = jm_q;
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = 1'b0;
		cord_start = 1'b0;
		we_p = 1'b0;
		we_d = 1'b0;
		wdata_p = r_sat;
		wdata_d = r_sat;
		waddr = {jn_q, wm};
		raddr = {en_q[NW-1:0], em_q[NW-1:0]};
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cord_start = s_axis_tvalid;
			end
			ST_INIT: begin
				we_p = 1'b1;
				we_d = 1'b1;
				wdata_p = ONE_Q24;
				wdata_d = '0;
				waddr = '0;
			end
			ST_LD0:  raddr = {jn_q - NW'(1), jcol_q ? jm_q : jn_q - NW'(1)};
			ST_LD1:  raddr = {jn_q - NW'(2), jm_q};
			ST_WB: begin
				we_p = (uop.dst == DST_WR_P);
				we_d = (uop.dst == DST_WR_D);
			end
			ST_EM_OUT: m_axis_tvalid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_p) mem_p[waddr] <= wdata_p;
		if (we_d) mem_d[waddr] <= wdata_d;
		rd_p_q <= mem_p[raddr];
		rd_d_q <= mem_d[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			jn_q <= '0;
			jm_q <= '0;
			jcol_q <= 1'b0;
			pc_q <= '0;
			en_q <= '0;
			em_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_INIT: begin
					jn_q <= NW'(1);
					jm_q <= '0;
					jcol_q <= 1'b0;
					pc_q <= '0;
					en_q <= '0;
					em_q <= '0;
				end
				ST_WB: begin
					if (!uop.last) begin
						pc_q <= pc_q + PC_W'(1);
					end else begin
						pc_q <= '0;
						priority if (!jcol_q && jn_q == MAXN) begin
							jcol_q <= 1'b1;
							jm_q <= '0;
							jn_q <= NW'(2);
						end else if (jcol_q && jn_q == MAXN) begin
							jm_q <= jm_q + NW'(1);
							jn_q <= jm_q + NW'(3);
						end else begin
							jn_q <= jn_q + NW'(1);
						end
					end
				end
				ST_EM_LD: out_last_q <= em_last;
				ST_EM_OUT: begin
					if (m_axis_tready) begin
						if (em_q == max_order_q) begin
							em_q <= '0;
							en_q <= en_q + FLD_W'(1);
						end else begin
							em_q <= em_q + FLD_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LD1: begin
				p1_q <= rd_p_q;
				d1_q <= rd_d_q;
			end
			ST_LD2: begin
				p2_q <= rd_p_q;
				d2_q <= rd_d_q;
			end
			ST_MUL: prod_s1 <= PROD_W'(xs) * PROD_W'(kv);
			ST_WB: begin
				unique case (uop.dst)
					DST_TMP: tmp_q <= r;
					DST_LD:  acc_q <= r_ext;
					DST_ADD: acc_q <= acc_q + r_ext;
					DST_SUB: acc_q <= acc_q - r_ext;
					default: ;
				endcase
			end
			ST_EM_LD: begin
				out_deg_q <= en_q;
				out_ord_q <= em_q;
				if (em_q <= en_q) begin
					out_val_q <= rd_p_q >>> OUT_SH;
					out_der_q <= rd_d_q >>> OUT_SH;
				end else begin
					out_val_q <= '0;
					out_der_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tdata = {2'b00, out_der_q, out_val_q, out_ord_q, out_deg_q};
	assign m_axis_tlast = out_last_q;

`ifndef SYNTHESIS
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while a result beat is pending");
	a_cord_done: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> state_q == ST_CORDIC)
		else $error("sine/cosine finished outside the rotation phase");
	a_mem_we: assert property (@(posedge clk) disable iff (!arst_n)
		(we_p || we_d) |-> (state_q == ST_WB || state_q == ST_INIT))
		else $error("table write outside compute phase");
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (out_ord_q == max_order_q && out_deg_q == nd))
		else $error("last beat not at the final entry");
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
		else $error("not idle after the last beat");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/normalized_legendre_table_core_test.sv
`default_nettype none
module normalized_legendre_table_core_test;
	import nlt_pkg::*;

	localparam int N_RANDOM = 450;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam longint PI_Q30_L = 64'sd3373259426;
	localparam longint HALF_PI_L = 64'sd1686629713;
	localparam longint ENT_LIM = 64'sd2147483647;

	typedef struct packed {
		logic [2:0]  degree;
		logic [2:0]  order;
		logic [31:0] value;
		logic [31:0] derivative;
		logic        last;
	} entry_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FLD_W-1:0] cfg_data;

	normalized_legendre_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [30:0] angle_queue[$];
	entry_t expected_entries[$];
	logic [2:0] deg_limit;
	logic [2:0] ord_limit;
	longint atan_tab[30];
	int errors;
	int tables_done;
	int entries_seen;
	longint cycles;
	bit idle_free;
	bit hold_sender;
	int send_gap;
	int recv_gap;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip31(longint v);
		if (v > ENT_LIM) return ENT_LIM;
		if (v < -ENT_LIM) return -ENT_LIM;
		return v;
	endfunction

	function automatic longint qmul(longint x, longint k);
		return floor_shr(clip31(x) * k, 30);
	endfunction

	function automatic longint root64(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	function automatic longint sqrt_ratio(longint unsigned p, longint unsigned q);
		longint unsigned u;
		u = p << 56;
		return root64(((u / q) << 4) + (((u % q) << 4) / q));
	endfunction

	function automatic logic [31:0] q20_out(longint v);
		return 32'(clip31(floor_shr(v, 4)));
	endfunction

	// Build the whole table for one angle and push the emitted entries.
	task automatic predict_table(input logic [30:0] angle);
		longint pt[8][8];
		longint dt[8][8];
		longint z;
		longint x;
		longint y;
		longint dx;
		longint dy;
		longint cs;
		longint sn;
		longint dg;
		longint e;
		longint ka;
		longint kb;
		longint kc;
		longint t;
		bit flip;
		entry_t ent;
		z = longint'($signed(angle)) * 4;
		flip = 1'b0;
		if (z > HALF_PI_L) begin
			z = z - PI_Q30_L;
			flip = 1'b1;
		end else if (z < -HALF_PI_L) begin
			z = z + PI_Q30_L;
			flip = 1'b1;
		end
		x = 652032874;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - atan_tab[i];
			end else begin
				x = x + dx; y = y - dy; z = z + atan_tab[i];
			end
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
		for (int a = 0; a < 8; a++)
			for (int b = 0; b < 8; b++) begin
				pt[a][b] = 0;
				dt[a][b] = 0;
			end
		pt[0][0] = 64'sd1 << 24;
		for (int n = 1; n <= 7; n++) begin
			dg = (n == 1) ? sqrt_ratio(3, 1) : sqrt_ratio(2 * n + 1, 2 * n);
			e = sqrt_ratio(2 * n + 1, 1);
			pt[n][n] = clip31(qmul(qmul(pt[n-1][n-1], cs), dg));
			dt[n][n] = clip31(qmul(qmul(dt[n-1][n-1], cs) - qmul(pt[n-1][n-1], sn), dg));
			pt[n][n-1] = clip31(qmul(qmul(pt[n-1][n-1], sn), e));
			dt[n][n-1] = clip31(qmul(qmul(pt[n-1][n-1], cs) + qmul(dt[n-1][n-1], sn), e));
		end
		for (int m = 0; m + 2 <= 7; m++)
			for (int n = m + 2; n <= 7; n++) begin
				ka = sqrt_ratio(2 * n + 1, (n - m) * (n + m));
				kb = sqrt_ratio(2 * n - 1, 1);
				kc = sqrt_ratio((n + m - 1) * (n - m - 1), 2 * n - 3);
				t = qmul(qmul(pt[n-1][m], sn), kb) - qmul(pt[n-2][m], kc);
				pt[n][m] = clip31(qmul(t, ka));
				t = qmul(qmul(dt[n-1][m], sn), kb) + qmul(qmul(pt[n-1][m], cs), kb)
					- qmul(dt[n-2][m], kc);
				dt[n][m] = clip31(qmul(t, ka));
			end
		for (int n = 0; n <= deg_limit; n++)
			for (int m = 0; m <= ord_limit; m++) begin
				ent.degree = 3'(n);
				ent.order = 3'(m);
				ent.value = (m <= n) ? q20_out(pt[n][m]) : 32'd0;
				ent.derivative = (m <= n) ? q20_out(dt[n][m]) : 32'd0;
				ent.last = (n == deg_limit && m == ord_limit);
				expected_entries.push_back(ent);
			end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap <= 0;
		end else begin
			// the accepted angle leaves the queue here, so its front is the next one
			if (s_axis_tvalid && s_axis_tready) begin
				predict_table(s_axis_tdata[30:0]);
				void'(angle_queue.pop_front());
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the beat
			end else if (send_gap > 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (hold_sender || angle_queue.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (!idle_free && $urandom_range(0, 5) == 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap <= $urandom_range(0, 4);
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {1'b0, angle_queue[0]};
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		entry_t got;
		entry_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.degree = m_axis_tdata[2:0];
				got.order = m_axis_tdata[5:3];
				got.value = m_axis_tdata[37:6];
				got.derivative = m_axis_tdata[69:38];
				got.last = m_axis_tlast;
				entries_seen++;
				if (expected_entries.size() == 0) begin
					$error("unexpected entry degree %0d order %0d", got.degree, got.order);
					errors++;
				end else begin
					want = expected_entries.pop_front();
					if (got.degree !== want.degree) begin
						$error("degree: expected %0d, got %0d", want.degree, got.degree);
						errors++;
					end
					if (got.order !== want.order) begin
						$error("order: expected %0d, got %0d", want.order, got.order);
						errors++;
					end
					if (got.value !== want.value) begin
						$error("value: expected %0d, got %0d", $signed(want.value),
							$signed(got.value));
						errors++;
					end
					if (got.derivative !== want.derivative) begin
						$error("derivative: expected %0d, got %0d",
							$signed(want.derivative), $signed(got.derivative));
						errors++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, got.last);
						errors++;
					end
					if (want.last) tables_done++;
				end
			end
			if (recv_gap > 0) begin
				m_axis_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else if (!idle_free && $urandom_range(0, 6) == 0) begin
				m_axis_tready <= 1'b0;
				recv_gap <= $urandom_range(0, 4);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic drain();
		while (angle_queue.size() != 0 || s_axis_tvalid || expected_entries.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [2:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_MAX_DEGREE) deg_limit = val;
		else if (idx == REG_MAX_ORDER) ord_limit = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_angles(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				angle_queue.push_back(31'($signed($urandom_range(0, 1686629712)) - 843314856));
			else if (pick < 9)
				angle_queue.push_back(31'($urandom));
			else
				angle_queue.push_back(31'($urandom_range(0, 7)) ^ {31{pick[0]}});
		end
	endtask

	initial begin
		logic [30:0] directed[$];
		int count;
		atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
			16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
			65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
			15, 7, 3, 1};
		errors = 0;
		tables_done = 0;
		entries_seen = 0;
		cycles = 0;
		idle_free = 1'b0;
		hold_sender = 1'b0;
		deg_limit = 3'd7;
		ord_limit = 3'd7;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// zero, +-half pi edges, beyond +-pi, field extremes, full-range corners
		directed = '{31'd0, 31'd1, 31'h7FFFFFFF, 31'd421657428, 31'd421657429,
			-31'sd421657428, -31'sd421657429, 31'd843314857, -31'sd843314857,
			31'h3FFFFFFF, 31'h40000000, 31'd210828714, -31'sd210828714,
			31'h2AAAAAAA, 31'h55555555};
		foreach (directed[i]) angle_queue.push_back(directed[i]);
		drain();
		write_reg(REG_MAX_DEGREE, 3'd0);
		write_reg(REG_MAX_ORDER, 3'd0);
		angle_queue.push_back(31'd123456789);
		angle_queue.push_back(-31'sd300000000);
		drain();
		write_reg(REG_MAX_DEGREE, 3'd1);
		write_reg(REG_MAX_ORDER, 3'd7);
		angle_queue.push_back(31'd400000000);
		angle_queue.push_back(31'h7FFFFFF0);
		drain();
		write_reg(REG_MAX_DEGREE, 3'd7);
		write_reg(REG_MAX_ORDER, 3'd0);
		angle_queue.push_back(-31'sd100000000);
		drain();
		write_reg(2'd2, 3'd5);
		write_reg(2'd3, 3'd2);
		count = 0;
		while (count < N_RANDOM) begin
			write_reg(REG_MAX_DEGREE, 3'($urandom_range(0, 7)));
			write_reg(REG_MAX_ORDER, 3'($urandom_range(0, 7)));
			if (count >= N_RANDOM - 50) idle_free = 1'b1;
			add_angles(50);
			count += 50;
			// pause the sender once until the output side is empty
			if (count == 100) begin
				while (angle_queue.size() > 25) @(posedge clk);
				hold_sender = 1'b1;
				while (s_axis_tvalid || expected_entries.size() != 0) @(posedge clk);
				hold_sender = 1'b0;
			end
			drain();
		end
		$display("Checked %0d entries from %0d tables over several degree/order limits.",
			entries_seen, tables_done);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
src/nlt_pkg.sv
src/nlt_cordic.sv
src/normalized_legendre_table_core.sv
tb/sv/normalized_legendre_table_core_test.sv
